@@ src/grouped_top_k_smallest_list_assert.svh @@
// Assertion macros for the grouped top-K list checker.
// No dependencies; clock clk and reset rst must be in scope where used.
`ifndef GROUPED_TOP_K_SMALLEST_LIST_ASSERT_SVH
`define GROUPED_TOP_K_SMALLEST_LIST_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GTKSL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Next-cycle implication, disabled during reset.
`define GTKSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/gtksl_pkg.sv @@
// Shared types and constants for the grouped top-K smallest list.
// No dependencies.
package gtksl_pkg;

  localparam int SCORE_W        = 32;
  localparam int TAG_W          = 18;
  localparam int CNT_W          = 4;
  localparam int KIND_W         = 2;
  localparam int LIST_DEPTH_DEF = 10;

  localparam logic signed [SCORE_W-1:0] RESET_THRESHOLD = 32'sd1000000;

  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OFFER,
    S_DUMP
  } state_t;

  typedef struct packed {
    logic capture;    // latch the input word
    logic do_offer;   // compare/insert and load the acknowledge
    logic dump_emit;  // load one dump word
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a word this cycle
    logic dump_last;  // current dump word is the final one
  } ctrl_status_t;

endpackage

@@ src/gtksl_ctrl.sv @@
// Controller FSM for the grouped top-K list: sequences offers and dumps.
// Depends on gtksl_pkg.
module gtksl_ctrl
  import gtksl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         op,
  input  ctrl_status_t status,
  output logic         in_ready,
  output ctrl_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = op ? S_DUMP : S_OFFER;
        end
      end
      S_OFFER: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (status.out_free && status.dump_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == S_IDLE);
    cmd.capture   = in_valid && (state == S_IDLE);
    cmd.do_offer  = (state == S_OFFER) && status.out_free;
    cmd.dump_emit = (state == S_DUMP) && status.out_free;
  end

endmodule

@@ src/gtksl_dp.sv @@
// Datapath for the grouped top-K list: sorted cell rows, fill counts,
// threshold register and output register. Depends on gtksl_pkg.
module gtksl_dp
  import gtksl_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ctrl_cmd_t                 cmd,
  output ctrl_status_t              status,
  input  logic                      cfg_we,
  input  logic signed [SCORE_W-1:0] cfg_wdata,
  input  logic                      group,
  input  logic signed [SCORE_W-1:0] score,
  input  logic        [TAG_W-1:0]   tag,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic        [KIND_W-1:0]  kind,
  output logic                      accepted,
  output logic        [CNT_W-1:0]   fill_count,
  output logic        [CNT_W-1:0]   rank,
  output logic signed [SCORE_W-1:0] entry_score,
  output logic        [TAG_W-1:0]   entry_tag,
  output logic                      last
);

  localparam int FILL_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  // Per-group rows of cells, sorted ascending below the fill count.
  logic signed [SCORE_W-1:0] kept_scores [2][LIST_DEPTH];
  logic        [TAG_W-1:0]   kept_tags   [2][LIST_DEPTH];
  logic        [FILL_W-1:0]  fill        [2];

  logic signed [SCORE_W-1:0] empty_thr;
  logic                      grp;
  logic signed [SCORE_W-1:0] sc;
  logic        [TAG_W-1:0]   tg;
  logic        [IDX_W-1:0]   idx;

  logic        [FILL_W-1:0]  cur_fill, nlim, fill_new, idx_inc;
  logic                      full, acc;
  logic signed [SCORE_W-1:0] thr;
  logic                      le      [LIST_DEPTH];
  logic                      prev_le [LIST_DEPTH];
  logic signed [SCORE_W-1:0] nxt_sc  [LIST_DEPTH];
  logic        [TAG_W-1:0]   nxt_tg  [LIST_DEPTH];

  always_comb begin
    cur_fill = fill[grp];
    full     = (cur_fill == FILL_W'(LIST_DEPTH));
    thr      = full ? kept_scores[grp][LIST_DEPTH-1] : empty_thr;
    acc      = (sc < thr);
    nlim     = full ? FILL_W'(LIST_DEPTH - 1) : cur_fill;
    fill_new = full ? cur_fill : cur_fill + FILL_W'(1);
    idx_inc  = FILL_W'(idx) + FILL_W'(1);

    // Entries at or below the new score stay; the first one above takes
    // the new word, the rest move up one cell.
    for (int i = 0; i < LIST_DEPTH; i++) begin
      le[i] = (FILL_W'(i) < nlim) && (kept_scores[grp][i] <= sc);
    end
    prev_le[0] = 1'b1;
    for (int i = 1; i < LIST_DEPTH; i++) begin
      prev_le[i] = le[i-1];
    end
    nxt_sc[0] = le[0] ? kept_scores[grp][0] : sc;
    nxt_tg[0] = le[0] ? kept_tags[grp][0] : tg;
    for (int i = 1; i < LIST_DEPTH; i++) begin
      if (le[i]) begin
        nxt_sc[i] = kept_scores[grp][i];
        nxt_tg[i] = kept_tags[grp][i];
      end else if (prev_le[i]) begin
        nxt_sc[i] = sc;
        nxt_tg[i] = tg;
      end else begin
        nxt_sc[i] = kept_scores[grp][i-1];
        nxt_tg[i] = kept_tags[grp][i-1];
      end
    end

    status.out_free  = !out_valid || out_ready;
    status.dump_last = (cur_fill == '0) || (idx_inc == cur_fill);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      grp <= group;
      sc  <= score;
      tg  <= tag;
    end
    if (cmd.do_offer && acc) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
        kept_scores[grp][i] <= nxt_sc[i];
        kept_tags[grp][i]   <= nxt_tg[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_thr <= RESET_THRESHOLD;
      fill[0]   <= '0;
      fill[1]   <= '0;
      idx       <= '0;
    end else begin
      if (cfg_we) begin
        empty_thr <= cfg_wdata;
      end
      if (cmd.do_offer && acc) begin
        fill[grp] <= fill_new;
      end
      if (cmd.capture) begin
        idx <= '0;
      end else if (cmd.dump_emit) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.do_offer || cmd.dump_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_offer) begin
      kind        <= KIND_ACK;
      accepted    <= acc;
      fill_count  <= CNT_W'(acc ? fill_new : cur_fill);
      rank        <= '0;
      entry_score <= '0;
      entry_tag   <= '0;
      last        <= 1'b1;
    end else if (cmd.dump_emit) begin
      accepted <= 1'b0;
      if (cur_fill == '0) begin
        kind        <= KIND_EMPTY;
        fill_count  <= '0;
        rank        <= '0;
        entry_score <= '0;
        entry_tag   <= '0;
        last        <= 1'b1;
      end else begin
        kind        <= KIND_ENTRY;
        fill_count  <= CNT_W'(cur_fill);
        rank        <= CNT_W'(idx);
        entry_score <= kept_scores[grp][idx];
        entry_tag   <= kept_tags[grp][idx];
        last        <= (idx_inc == cur_fill);
      end
    end
  end

endmodule

@@ src/grouped_top_k_smallest_list.sv @@
// Top level of the grouped top-K smallest-score list block.
// Depends on gtksl_pkg, gtksl_ctrl and gtksl_dp.
//
//   channel  signals                                   direction
//   -------  ----------------------------------------  ---------
//   in       in_valid/in_ready, op group score tag     into block
//   out      out_valid/out_ready, kind accepted        out of block
//            fill_count rank entry_score entry_tag last
//   cfg      cfg_we, cfg_wdata (empty threshold)       into block
//
// An offer first captures the word, then does the parallel
// compare-and-shift over the group's cell row, which loads the acknowledge.
// A dump emits max(1, n) output words, n the fill, one per cycle while the output is free.
// The next input word is taken as soon as the controller is back in idle,
// even while the final output word still waits in the output register.
// A stalled output holds the word and freezes the sequence; no word drops.
// Reset (rst, synchronous) clears fill counts and the FSM and loads the
// empty threshold with 1000000; list contents need no clearing.
module grouped_top_k_smallest_list
  import gtksl_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      op,
  input  logic                      group,
  input  logic signed [SCORE_W-1:0] score,
  input  logic        [TAG_W-1:0]   tag,
  // output channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic        [KIND_W-1:0]  kind,
  output logic                      accepted,
  output logic        [CNT_W-1:0]   fill_count,
  output logic        [CNT_W-1:0]   rank,
  output logic signed [SCORE_W-1:0] entry_score,
  output logic        [TAG_W-1:0]   entry_tag,
  output logic                      last,
  // configuration
  input  logic                      cfg_we,
  input  logic signed [SCORE_W-1:0] cfg_wdata
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Sequencer: idle / offer / dump.
  gtksl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Cell rows, threshold and output word register.
  gtksl_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .group       (group),
    .score       (score),
    .tag         (tag),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .kind        (kind),
    .accepted    (accepted),
    .fill_count  (fill_count),
    .rank        (rank),
    .entry_score (entry_score),
    .entry_tag   (entry_tag),
    .last        (last)
  );

endmodule

@@ src/gtksl_checker.sv @@
// Port-level checker for the grouped top-K list, bound to the top level.
// Depends on gtksl_pkg and grouped_top_k_smallest_list_assert.svh.
`include "grouped_top_k_smallest_list_assert.svh"

module gtksl_checker
  import gtksl_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic        [KIND_W-1:0]  kind,
  input logic                      accepted,
  input logic        [CNT_W-1:0]   fill_count,
  input logic        [CNT_W-1:0]   rank,
  input logic signed [SCORE_W-1:0] entry_score,
  input logic        [TAG_W-1:0]   entry_tag,
  input logic                      last
);

  localparam int WORD_W = KIND_W + 2*CNT_W + SCORE_W + TAG_W + 2;

  logic [WORD_W-1:0] out_word;
  logic              out_stall;
  logic              ack_ok, empty_ok, entry_ok;

  assign out_word  = {kind, accepted, fill_count, rank, entry_score, entry_tag, last};
  assign out_stall = out_valid && !out_ready;

  assign ack_ok   = last && rank == '0 && entry_score == '0 && entry_tag == '0
                    && (!accepted || fill_count != '0);
  assign empty_ok = last && fill_count == '0 && !accepted;
  assign entry_ok = rank < fill_count && !accepted
                    && last == ((rank + CNT_W'(1)) == fill_count);

  // Pending output word is held until taken.
  `GTKSL_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "held word changed")

  // One input word at a time: ready drops right after a take.
  `GTKSL_ASSERT_NEXT(a_in_busy, in_valid && in_ready, !in_ready, "input taken while busy")

  // Acknowledge is a single word with zeroed entry fields.
  `GTKSL_ASSERT(a_ack_form, (out_valid && kind == KIND_ACK) |-> ack_ok, "bad acknowledge word")

  // Empty dump is a single word with nothing in it.
  `GTKSL_ASSERT(a_empty_form, (out_valid && kind == KIND_EMPTY) |-> empty_ok, "bad empty word")

  // Dumped entries stay inside the fill and flag the final rank.
  `GTKSL_ASSERT(a_entry_rank, (out_valid && kind == KIND_ENTRY) |-> entry_ok, "bad entry rank")

endmodule

bind grouped_top_k_smallest_list gtksl_checker u_gtksl_checker (.*);
